// ----- sv/cfq_pkg.sv -----
// Shared types and constants for the circular FIFO queue.
package cfq_pkg;

  // Default sizing, handed to the top-level parameters
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed field widths of the ports
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ITEM_W     = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CAP_W      = 5;

  // Register port
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned REG_CAP    = 0;
  localparam int unsigned CAP_RESET  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_DUMP    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Source of the result data word
  typedef enum logic [1:0] {
    DSEL_ZERO,
    DSEL_MEM,
    DSEL_ONES
  } dsel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    accept;   // latch a new request, start walk at head
    logic    load;     // load the result register
    logic    push;     // write item at tail, advance tail, count up
    logic    pop;      // advance head, count down
    logic    advance;  // step the dump walk
    status_e status;
    dsel_e   data_sel;
    logic    last;
  } ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic dump_last;
  } stat_t;

endpackage

// ----- sv/cfq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module cfq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on enable, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/cfq_ctrl.sv -----
// Controller state machine: sequences one request at a time and owns result valid.
module cfq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [cfq_pkg::CMD_W-1:0]   command_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  cfq_pkg::stat_t              stat_i,
  output cfq_pkg::ctrl_t              ctrl_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e         state_q, state_d;
  cfq_pkg::cmd_e  cmd_q, cmd_d;
  logic           out_valid_q, out_valid_d;
  logic           out_free;
  cfq_pkg::ctrl_t ctrl;

  // Result register may take a new result when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  // Decode state and status into datapath commands
  always_comb begin
    ctrl          = '0;
    ctrl.status   = cfq_pkg::ST_DONE;
    ctrl.data_sel = cfq_pkg::DSEL_ZERO;
    state_d       = state_q;
    cmd_d         = cmd_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl.accept = 1'b1;
          cmd_d       = cfq_pkg::cmd_e'(command_i);
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          ctrl.load = 1'b1;
          ctrl.last = 1'b1;
          state_d   = S_IDLE;
          unique case (cmd_q)
            cfq_pkg::CMD_ENQUEUE: begin
              if (stat_i.full) begin
                ctrl.status = cfq_pkg::ST_FULL;
              end else begin
                ctrl.push = 1'b1;
              end
            end
            cfq_pkg::CMD_DEQUEUE: begin
              if (stat_i.empty) begin
                ctrl.status = cfq_pkg::ST_EMPTY;
              end else begin
                ctrl.pop      = 1'b1;
                ctrl.data_sel = cfq_pkg::DSEL_MEM;
              end
            end
            cfq_pkg::CMD_PEEK: begin
              if (stat_i.empty) begin
                ctrl.status   = cfq_pkg::ST_EMPTY;
                ctrl.data_sel = cfq_pkg::DSEL_ONES;
              end else begin
                ctrl.data_sel = cfq_pkg::DSEL_MEM;
              end
            end
            cfq_pkg::CMD_DUMP: begin
              if (stat_i.empty) begin
                ctrl.status = cfq_pkg::ST_EMPTY;
              end else begin
                ctrl.data_sel = cfq_pkg::DSEL_MEM;
                ctrl.advance  = 1'b1;
                ctrl.last     = stat_i.dump_last;
                if (!stat_i.dump_last) begin
                  state_d = S_EXEC;
                end
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold result valid until taken, raise it on a new result
  always_comb begin
    if (ctrl.load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= cfq_pkg::CMD_ENQUEUE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign ctrl_o      = ctrl;

  // A new result never overwrites one that is still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while held");

  // Push and pop never happen in the same cycle
  a_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.push && ctrl.pop))
    else $error("push and pop together");

  // The final result of a request frees the controller
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.load && ctrl.last) |=> (state_q == S_IDLE))
    else $error("controller busy after final result");

endmodule

// ----- sv/cfq_dp.sv -----
// Datapath: pointers, count, capacity register, entry RAM and result register.
module cfq_dp #(
  parameter int unsigned DEPTH      = cfq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = cfq_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cfq_pkg::PADDR_W-1:0]       paddr,
  input  logic [cfq_pkg::PDATA_W-1:0]       pwdata,
  output logic [cfq_pkg::PDATA_W-1:0]       prdata,
  input  logic signed [cfq_pkg::ITEM_W-1:0] item_value_i,
  input  cfq_pkg::ctrl_t                    ctrl_i,
  output cfq_pkg::stat_t                    stat_o,
  output logic signed [cfq_pkg::ITEM_W-1:0] data_value_o,
  output logic [cfq_pkg::STATUS_W-1:0]      status_o,
  output logic                              is_empty_o,
  output logic                              is_full_o,
  output logic [cfq_pkg::COUNT_W-1:0]       entry_count_o,
  output logic                              last_result_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CAP_RST_VAL =
    (cfq_pkg::CAP_RESET > DEPTH) ? DEPTH : cfq_pkg::CAP_RESET;
  localparam int unsigned WIDE_W = 64;

  logic [CNT_W-1:0]      cap_q, cap_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      remain_q, remain_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [IDX_W-1:0]      tail_q, tail_d;
  logic [IDX_W-1:0]      walk_q, walk_d;
  logic [IDX_W-1:0]      raddr;
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] wdata;
  logic [WIDE_W-1:0]     item_wide;
  logic [cfq_pkg::ITEM_W-1:0] item_q;
  logic                  cap_sel;
  logic                  cfg_we;
  logic [cfq_pkg::CAP_W-1:0] cap_wr;
  logic [CNT_W-1:0]      cap_clamped;

  logic signed [cfq_pkg::ITEM_W-1:0] data_q, data_d;
  logic [cfq_pkg::STATUS_W-1:0]      status_q;
  logic                              empty_q, full_q, last_q;
  logic [cfq_pkg::COUNT_W-1:0]       ocount_q;

  // Step an index around the ring at the capacity in use
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(idx) + CNT_W'(1);
    return (n >= cap) ? '0 : IDX_W'(n);
  endfunction

  // Decode register writes and clamp the capacity to 1..DEPTH
  assign cap_sel = (paddr[cfq_pkg::PADDR_W-1:2] ==
                    (cfq_pkg::PADDR_W-2)'(cfq_pkg::REG_CAP));
  assign cfg_we  = psel && penable && pwrite && cap_sel;
  assign cap_wr  = pwdata[cfq_pkg::CAP_W-1:0];

  always_comb begin
    if (cap_wr == '0) begin
      cap_clamped = CNT_W'(1);
    end else if (32'(cap_wr) > DEPTH) begin
      cap_clamped = CNT_W'(DEPTH);
    end else begin
      cap_clamped = CNT_W'(cap_wr);
    end
  end

  // Read back the capacity register
  assign prdata = cap_sel ? cfq_pkg::PDATA_W'(cap_q) : '0;

  // Next pointer, count and walk values
  always_comb begin
    cap_d    = cap_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    walk_d   = walk_q;
    remain_d = remain_q;
    if (ctrl_i.accept) begin
      walk_d   = head_q;
      remain_d = count_q;
    end
    if (ctrl_i.push) begin
      tail_d  = ring_next(tail_q, cap_q);
      count_d = count_q + CNT_W'(1);
    end
    if (ctrl_i.pop) begin
      head_d  = ring_next(head_q, cap_q);
      count_d = count_q - CNT_W'(1);
    end
    if (ctrl_i.advance) begin
      walk_d   = ring_next(walk_q, cap_q);
      remain_d = remain_q - CNT_W'(1);
    end
    if (cfg_we) begin
      cap_d   = cap_clamped;
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end
  end

  // Hold pointers, count and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CNT_W'(CAP_RST_VAL);
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      cap_q   <= cap_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Latch the request item and the dump walk
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      item_q <= item_value_i;
    end
    walk_q   <= walk_d;
    remain_q <= remain_d;
  end

  // Read the head on accept, the next entry while the dump advances
  always_comb begin
    if (ctrl_i.accept) begin
      raddr = head_q;
    end else if (ctrl_i.advance) begin
      raddr = ring_next(walk_q, cap_q);
    end else begin
      raddr = walk_q;
    end
  end

  // Keep the low DATA_WIDTH bits of the item
  assign item_wide = {{(WIDE_W - cfq_pkg::ITEM_W){1'b0}}, item_q};
  assign wdata     = item_wide[DATA_WIDTH-1:0];

  cfq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push),
    .waddr_i (tail_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Select the result word
  always_comb begin
    unique case (ctrl_i.data_sel)
      cfq_pkg::DSEL_MEM:  data_d = cfq_pkg::ITEM_W'($signed(rdata));
      cfq_pkg::DSEL_ONES: data_d = '1;
      default:            data_d = '0;
    endcase
  end

  // Load the result register with flags as they stand after the request
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      data_q   <= data_d;
      status_q <= ctrl_i.status;
      empty_q  <= (count_d == '0);
      full_q   <= (count_d == cap_q);
      ocount_q <= cfq_pkg::COUNT_W'(count_d);
      last_q   <= ctrl_i.last;
    end
  end

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q >= cap_q);
  assign stat_o.dump_last = (remain_q == CNT_W'(1));

  assign data_value_o  = data_q;
  assign status_o      = status_q;
  assign is_empty_o    = empty_q;
  assign is_full_o     = full_q;
  assign entry_count_o = ocount_q;
  assign last_result_o = last_q;

  // Count stays within the capacity in use
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("count above capacity");

  // Pointers stay inside the ring
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W'(head_q) < cap_q) && (CNT_W'(tail_q) < cap_q))
    else $error("pointer outside ring");

  // A push is only issued while room remains
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> (count_q < cap_q))
    else $error("push on full queue");

endmodule

// ----- sv/circular_fifo_queue_top.sv -----
// Top level of the circular FIFO queue: controller, datapath and register port.
//
// A ring-buffer FIFO of signed words with a programmable capacity (register 0,
// clamped to 1..DEPTH; writing it empties the queue). Commands enqueue,
// dequeue, peek the head, or dump all held entries head to tail. One request
// is worked at a time: enqueue, dequeue and peek are accepted, then the result
// is loaded once the registered read of the entry RAM is ready; a dump of n
// entries loads one entry per cycle through the same RAM read port, as long
// as the output is not stalled. A stalled output adds its stall cycles. A new
// request is accepted while the previous result still waits in the output
// register. The entry RAM needs no clearing after reset.
module circular_fifo_queue_top #(
  parameter int unsigned DEPTH      = cfq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = cfq_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cfq_pkg::PADDR_W-1:0]       paddr,
  input  logic [cfq_pkg::PDATA_W-1:0]       pwdata,
  output logic [cfq_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cfq_pkg::CMD_W-1:0]         command_i,
  input  logic signed [cfq_pkg::ITEM_W-1:0] item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cfq_pkg::ITEM_W-1:0] data_value_o,
  output logic [cfq_pkg::STATUS_W-1:0]      status_o,
  output logic                              is_empty_o,
  output logic                              is_full_o,
  output logic [cfq_pkg::COUNT_W-1:0]       entry_count_o,
  output logic                              last_result_o
);

  cfq_pkg::ctrl_t ctrl;
  cfq_pkg::stat_t stat;

  assign pready = 1'b1;

  cfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  cfq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .item_value_i  (item_value_i),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .data_value_o  (data_value_o),
    .status_o      (status_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .entry_count_o (entry_count_o),
    .last_result_o (last_result_o)
  );

endmodule
